@@ design/pba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants for the page bitmap allocator
// Operation codes, controller states and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int PAGE_W = 12;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCATE,
        ST_FETCH,
        ST_MODIFY,
        ST_SCAN,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic clear;      // write one zero word of the clearing pass
        logic capture;    // take the request, zero the pending result
        logic scan_init;  // restart the word scan at word zero
        logic locate;     // compute the word number of the page
        logic fetch;      // read the addressed word, take the bit number
        logic modify;     // write back the word for free or mark used
        logic scan_step;  // read the next word of the scan
        logic grant;      // set the found bit and record the page
        logic exhaust;    // record out of memory
        logic reply;      // load the output register
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic word_found;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

@@ design/page_bitmap_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator: first-fit physical page allocator
// One bit per page in a word-wide bitmap memory; allocate, free and
// mark-used requests, one result per request.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  request  in         i_valid / o_ready  i_operation, i_page_index
//  result   out        o_valid / i_ready  o_granted_page, o_out_of_memory
//
//  Free and mark used step through locate, fetch and modify before the reply;
//  an unused operation code goes straight to the reply.
//  Allocate reads the bitmap word by word from word zero up to the first
//  word with a free page, or all WORD_COUNT words (128 at the defaults)
//  when no page is free; the single read port of the bitmap memory reads
//  one word per cycle.
//  After reset a clearing pass writes WORD_COUNT words (128 at the
//  defaults) before the first request is taken.
//  A new request is taken while the previous result waits in the output
//  register; a stalled output holds the sequencer only in its last step.
//
module page_bitmap_allocator #(
    parameter int PAGE_COUNT = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [pba_pkg::OP_W-1:0]   i_operation,
    input  wire logic [pba_pkg::PAGE_W-1:0] i_page_index,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [pba_pkg::PAGE_W-1:0]      o_granted_page,
    output logic                           o_out_of_memory
);

    pba_pkg::t_cmd    cmd;
    pba_pkg::t_status status;

    pba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pba_datapath #(
        .PAGE_COUNT (PAGE_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_operation),
        .i_page_index    (i_page_index),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_granted_page  (o_granted_page),
        .o_out_of_memory (o_out_of_memory),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
`default_nettype wire

@@ design/pba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_ctrl: request sequencer
// Runs the clearing pass after reset, steps each free, mark or allocate request
// through locate/fetch/modify or the word scan and hands results to the output.
// ----------------------------------------------------------------------------
module pba_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [pba_pkg::OP_W-1:0] i_operation,
    output logic                         o_ready,
    input  wire pba_pkg::t_status        i_status,
    output pba_pkg::t_cmd                o_cmd
);

    pba_pkg::t_state r_state;
    pba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pba_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pba_pkg::ST_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = pba_pkg::ST_IDLE;
                end
            end
            pba_pkg::ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_operation) inside
                        pba_pkg::OP_ALLOC:                  n_state = pba_pkg::ST_SCAN;
                        pba_pkg::OP_FREE, pba_pkg::OP_MARK: n_state = pba_pkg::ST_LOCATE;
                        default:                            n_state = pba_pkg::ST_REPLY;
                    endcase
                end
            end
            pba_pkg::ST_LOCATE: n_state = pba_pkg::ST_FETCH;
            pba_pkg::ST_FETCH:  n_state = pba_pkg::ST_MODIFY;
            pba_pkg::ST_MODIFY: n_state = pba_pkg::ST_REPLY;
            pba_pkg::ST_SCAN: begin
                if (i_status.word_found || i_status.scan_last) begin
                    n_state = pba_pkg::ST_REPLY;
                end
            end
            pba_pkg::ST_REPLY: begin
                if (i_status.out_free) begin
                    n_state = pba_pkg::ST_IDLE;
                end
            end
            default: n_state = pba_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            pba_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            pba_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.scan_init = (i_operation == pba_pkg::OP_ALLOC);
                end
            end
            pba_pkg::ST_LOCATE: o_cmd.locate = 1'b1;
            pba_pkg::ST_FETCH:  o_cmd.fetch  = 1'b1;
            pba_pkg::ST_MODIFY: o_cmd.modify = 1'b1;
            pba_pkg::ST_SCAN: begin
                if (i_status.word_found) begin
                    o_cmd.grant = 1'b1;
                end else if (i_status.scan_last) begin
                    o_cmd.exhaust = 1'b1;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            pba_pkg::ST_REPLY: o_cmd.reply = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/pba_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_datapath: bitmap memory, page splitter, word scanner, result registers
// One write port and one registered read port on the bitmap. The scan keeps
// one read in flight and checks each word as its data returns.
// ----------------------------------------------------------------------------
module pba_datapath #(
    parameter int PAGE_COUNT = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [pba_pkg::OP_W-1:0]   i_operation,
    input  wire logic [pba_pkg::PAGE_W-1:0] i_page_index,
    input  wire logic                      i_ready,
    output logic                           o_valid,
    output logic [pba_pkg::PAGE_W-1:0]      o_granted_page,
    output logic                           o_out_of_memory,
    input  wire pba_pkg::t_cmd             i_cmd,
    output pba_pkg::t_status               o_status
);

    localparam int PW         = pba_pkg::PAGE_W;
    localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int LAST_WORD  = WORD_COUNT - 1;
    localparam int LAST_BITS  = PAGE_COUNT - LAST_WORD * WORD_BITS;
    // reciprocal of WORD_BITS, exact floor for any PW-bit page number
    localparam int DIV_SHIFT  = PW + BW;
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int MW         = PW + 2;
    localparam int PRODW      = PW + MW;

    localparam logic [AW-1:0] LAST_ADDR = AW'(LAST_WORD);

    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [PW-1:0]        r_page;
    logic [pba_pkg::OP_W-1:0] r_op;
    logic                 r_in_range;
    logic [AW-1:0]        r_word;
    logic [BW-1:0]        r_bit;

    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_scan_addr;
    logic [PW-1:0]        r_scan_base;
    logic                 r_scan_done;
    logic [AW-1:0]        r_rd_addr;
    logic [PW-1:0]        r_rd_base;
    logic                 r_rd_vld;

    logic [PW-1:0]        r_res_page;
    logic                 r_res_oom;
    logic                 r_out_valid;
    logic [PW-1:0]        r_out_page;
    logic                 r_out_oom;

    logic [PRODW-1:0]     quo_prod;
    logic [31:0]          rem_full;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] eff_word;
    logic                 word_full;
    logic [BW-1:0]        free_idx;
    logic [WORD_BITS-1:0] free_mask;
    logic [PW-1:0]        granted;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // page split: word = page / WORD_BITS, bit = page - word * WORD_BITS
    assign quo_prod  = PRODW'(r_page) * PRODW'(DIV_MULT);
    assign rem_full  = 32'(r_page) - 32'(r_word) * 32'(WORD_BITS);
    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;

    // treat pad bits of a partial last word as used
    always_comb begin
        eff_word = r_rd_data;
        if (r_rd_addr == LAST_ADDR) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (b >= LAST_BITS) begin
                    eff_word[b] = 1'b1;
                end
            end
        end
    end

    assign word_full = &eff_word;

    // lowest clear bit
    always_comb begin
        free_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!eff_word[b]) begin
                free_idx = BW'(b);
            end
        end
    end

    assign free_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << free_idx;
    assign granted   = r_rd_base + PW'(free_idx);

    always_comb begin
        rd_en   = i_cmd.fetch || (i_cmd.scan_step && !r_scan_done);
        rd_addr = i_cmd.fetch ? r_word : r_scan_addr;
        wr_en   = i_cmd.clear || i_cmd.grant || (i_cmd.modify && r_in_range);
        if (i_cmd.clear) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.grant) begin
            wr_addr = r_rd_addr;
            wr_data = r_rd_data | free_mask;
        end else if (r_op == pba_pkg::OP_MARK) begin
            wr_addr = r_word;
            wr_data = r_rd_data | bit_mask;
        end else begin
            wr_addr = r_word;
            wr_data = r_rd_data & ~bit_mask;
        end
    end

    // bitmap storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_scan_done <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear && r_clr_addr != LAST_ADDR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_scan_done <= 1'b0;
                r_rd_vld    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= !r_scan_done;
                if (r_scan_addr == LAST_ADDR) begin
                    r_scan_done <= 1'b1;
                end
            end
            if (i_cmd.reply) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_operation;
            r_page     <= i_page_index;
            r_in_range <= (32'(i_page_index) < 32'(PAGE_COUNT));
            r_res_page <= '0;
            r_res_oom  <= 1'b0;
        end
        if (i_cmd.locate) begin
            r_word <= AW'(quo_prod >> DIV_SHIFT);
        end
        if (i_cmd.fetch) begin
            r_bit <= rem_full[BW-1:0];
        end
        if (i_cmd.scan_init) begin
            r_scan_addr <= '0;
            r_scan_base <= '0;
        end else if (i_cmd.scan_step && !r_scan_done) begin
            r_rd_addr   <= r_scan_addr;
            r_rd_base   <= r_scan_base;
            r_scan_addr <= r_scan_addr + 1'b1;
            r_scan_base <= r_scan_base + PW'(WORD_BITS);
        end
        if (i_cmd.grant) begin
            r_res_page <= granted;
        end
        if (i_cmd.exhaust) begin
            r_res_oom <= 1'b1;
        end
        if (i_cmd.reply) begin
            r_out_page <= r_res_page;
            r_out_oom  <= r_res_oom;
        end
    end

    assign o_status.clear_done = (r_clr_addr == LAST_ADDR);
    assign o_status.word_found = r_rd_vld && !word_full;
    assign o_status.scan_last  = r_rd_vld && word_full && (r_rd_addr == LAST_ADDR);
    assign o_status.out_free   = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_granted_page  = r_out_page;
    assign o_out_of_memory = r_out_oom;

endmodule
`default_nettype wire

@@ design/pba_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pba_checker: port-level checks for the page bitmap allocator
// Watches the request and result channels and the reset behavior.
// ----------------------------------------------------------------------------
module pba_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [pba_pkg::PAGE_W-1:0] o_granted_page,
    input wire logic                      o_out_of_memory
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_granted_page)
                                && $stable(o_out_of_memory))
        else $error("result changed while stalled");

    // a failed allocate reports page zero
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_memory |-> o_granted_page == '0)
        else $error("out of memory with nonzero page");

    // the clearing pass blocks requests right after reset
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_ready)
        else $error("request taken during clearing pass");

    // one request at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken back to back");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_granted_page  (o_granted_page),
    .o_out_of_memory (o_out_of_memory)
);
`default_nettype wire
